// File: design/e2q_pkg.sv
// Package: widths, CORDIC constants and arctangent table for the Euler-to-quaternion block.
`timescale 1ns / 1ps
package e2q_pkg;
	localparam int AngleBits   = 16;
	localparam int OutFracBits = 15;
	localparam int OutBits     = OutFracBits + 1;
	localparam int CordicSteps = 30;
	localparam int CvBits      = 34;
	localparam int ZBits       = 34;
	localparam logic signed [CvBits-1:0] CordicGain = 34'sh026DD3B6A;
	localparam int InBits  = 3 * AngleBits;
	localparam int OutWord = 4 * OutBits;

	typedef logic signed [CvBits-1:0] cv_t;
	typedef logic signed [ZBits-1:0]  z_t;
	typedef logic signed [63:0]       q60_t;

	typedef struct packed {
		cv_t x;
		cv_t y;
		z_t  z;
	} rot_t;

	function automatic z_t atan_turn(input logic [4:0] i);
		case (i)
			5'd0: atan_turn = 34'sh020000000;
			5'd1: atan_turn = 34'sh012E4051E;
			5'd2: atan_turn = 34'sh009FB385B;
			5'd3: atan_turn = 34'sh0051111D4;
			5'd4: atan_turn = 34'sh0028B0D43;
			5'd5: atan_turn = 34'sh00145D7E1;
			5'd6: atan_turn = 34'sh000A2F61E;
			5'd7: atan_turn = 34'sh000517C55;
			5'd8: atan_turn = 34'sh00028BE53;
			5'd9: atan_turn = 34'sh000145F2F;
			5'd10: atan_turn = 34'sh0000A2F98;
			5'd11: atan_turn = 34'sh0000517CC;
			5'd12: atan_turn = 34'sh000028BE6;
			5'd13: atan_turn = 34'sh0000145F3;
			5'd14: atan_turn = 34'sh00000A2FA;
			5'd15: atan_turn = 34'sh00000517D;
			5'd16: atan_turn = 34'sh0000028BE;
			5'd17: atan_turn = 34'sh00000145F;
			5'd18: atan_turn = 34'sh000000A30;
			5'd19: atan_turn = 34'sh000000518;
			5'd20: atan_turn = 34'sh00000028C;
			5'd21: atan_turn = 34'sh000000146;
			5'd22: atan_turn = 34'sh0000000A3;
			5'd23: atan_turn = 34'sh000000051;
			5'd24: atan_turn = 34'sh000000029;
			5'd25: atan_turn = 34'sh000000014;
			5'd26: atan_turn = 34'sh00000000A;
			5'd27: atan_turn = 34'sh000000005;
			5'd28: atan_turn = 34'sh000000003;
			5'd29: atan_turn = 34'sh000000001;
			default: atan_turn = '0;
		endcase
	endfunction

	// one CORDIC micro-rotation; >>> floors
	function automatic rot_t cordic_step(input rot_t r, input logic [4:0] i);
		rot_t o;
		cv_t dx;
		cv_t dy;
		dx = r.y >>> i;
		dy = r.x >>> i;
		if (!r.z[ZBits-1]) begin
			o.x = r.x - dx;
			o.y = r.y + dy;
			o.z = r.z - atan_turn(i);
		end else begin
			o.x = r.x + dx;
			o.y = r.y - dy;
			o.z = r.z + atan_turn(i);
		end
		return o;
	endfunction

	function automatic rot_t cordic_init(input logic signed [AngleBits-1:0] a);
		rot_t o;
		o.x = CordicGain;
		o.y = '0;
		o.z = ZBits'(a) <<< (31 - AngleBits);
		return o;
	endfunction

	// Q30*Q30 -> rounded Q30
	function automatic cv_t round_q30(input q60_t p);
		q60_t t;
		t = (p + 64'sd536870912) >>> 30;
		return t[CvBits-1:0];
	endfunction

	function automatic logic [OutBits-1:0] to_out(input q60_t v);
		q60_t r;
		r = (v + (64'sd1 <<< (59 - OutFracBits))) >>> (60 - OutFracBits);
		if (r > q60_t'((64'sd1 <<< OutFracBits) - 1))
			return {1'b0, {(OutBits-1){1'b1}}};
		else if (r < -(64'sd1 <<< OutFracBits))
			return {1'b1, {(OutBits-1){1'b0}}};
		else
			return r[OutBits-1:0];
	endfunction
endpackage

// File: design/euler_to_quaternion.sv
// Euler angles (Z-Y-X) to unit quaternion, fully pipelined.
// Between accepted input word and output word lie an input stage, 30
// CORDIC stages, one per micro-rotation, then 5 stages of multiplies and
// rounding.
// Throughput: one word per cycle; the whole pipe advances when the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset (arst_n low, asynchronous) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
module euler_to_quaternion import e2q_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [InBits-1:0] s_tdata,   // pitch_angle, roll_angle, azimuth_angle
	output logic m_tvalid,
	input  logic m_tready,
	output logic [OutWord-1:0] m_tdata   // quat_w, quat_x, quat_y, quat_z
);
	localparam int Depth = CordicSteps + 6;

	logic [Depth-1:0] vld_q;
	logic adv;
	assign m_tvalid = vld_q[Depth-1];
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], s_tvalid};
		end
	end

	// CORDIC stages, three angles in parallel lanes
	rot_t cr_s [0:CordicSteps][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				cr_s[0][k] <= cordic_init(s_tdata[k*AngleBits +: AngleBits]);
				for (int g = 0; g < CordicSteps; g++)
					cr_s[g+1][k] <= cordic_step(cr_s[g][k], 5'(g));
			end
		end
	end

	cv_t cp, sp, cr, sr, cy, sy;
	assign cp = cr_s[CordicSteps-1+1][0].x;
	assign sp = cr_s[CordicSteps][0].y;
	assign cr = cr_s[CordicSteps][1].x;
	assign sr = cr_s[CordicSteps][1].y;
	assign cy = cr_s[CordicSteps][2].x;
	assign sy = cr_s[CordicSteps][2].y;

	// first products: cy*cr, sy*sr, cy*sr, sy*cr
	q60_t pa_s1 [4];
	cv_t cp_s1, sp_s1;
	cv_t ab_s2 [4];
	cv_t cp_s2, sp_s2;
	q60_t t_s3 [8];
	q60_t sum_s4 [4];
	logic [OutWord-1:0] out_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1[0] <= cy * cr;
			pa_s1[1] <= sy * sr;
			pa_s1[2] <= cy * sr;
			pa_s1[3] <= sy * cr;
			cp_s1 <= cp;
			sp_s1 <= sp;
			for (int k = 0; k < 4; k++)
				ab_s2[k] <= round_q30(pa_s1[k]);
			cp_s2 <= cp_s1;
			sp_s2 <= sp_s1;
			t_s3[0] <= ab_s2[0] * cp_s2;  // w
			t_s3[1] <= ab_s2[1] * sp_s2;
			t_s3[2] <= ab_s2[2] * cp_s2;  // x
			t_s3[3] <= ab_s2[3] * sp_s2;
			t_s3[4] <= ab_s2[0] * sp_s2;  // y
			t_s3[5] <= ab_s2[1] * cp_s2;
			t_s3[6] <= ab_s2[3] * cp_s2;  // z
			t_s3[7] <= ab_s2[2] * sp_s2;
			sum_s4[0] <= t_s3[0] + t_s3[1];
			sum_s4[1] <= t_s3[2] - t_s3[3];
			sum_s4[2] <= t_s3[4] + t_s3[5];
			sum_s4[3] <= t_s3[6] - t_s3[7];
			for (int k = 0; k < 4; k++)
				out_s5[k*OutBits +: OutBits] <= to_out(sum_s4[k]);
		end
	end
	assign m_tdata = out_s5;

`ifndef SYNTH
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(vld_q))
		else $error("pipe moved during stall");
`endif
endmodule

// File: tb/euler_to_quaternion_tb.sv
// Testbench for the Euler-to-quaternion converter: directed table plus random words.
`timescale 1ns / 1ps
module euler_to_quaternion_tb;
	import e2q_pkg::*;

	localparam int PipeLatency = 35;
	localparam int StallLimit  = 20000;
	localparam int NumRandom   = 1030;

	typedef logic signed [AngleBits-1:0] ang_t;
	typedef logic signed [OutBits-1:0]   qc_t;
	typedef struct {
		qc_t w;
		qc_t x;
		qc_t y;
		qc_t z;
	} quat_t;
	typedef struct {
		ang_t pitch;
		ang_t roll;
		ang_t azim;
		bit   known;
		quat_t q;
	} vec_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [InBits-1:0] s_tdata;   // pitch_angle, roll_angle, azimuth_angle
	logic m_tvalid;
	logic m_tready;
	logic [OutWord-1:0] m_tdata;  // quat_w, quat_x, quat_y, quat_z

	euler_to_quaternion u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	quat_t quat_q[$];
	int errors;
	int src_idle_pct;
	int snk_idle_pct;
	int hold_off;
	bit stim_done;
	int quiet;

	// arctangent of 2^-i, 2^32 per turn
	function automatic longint atan_of(int i);
		longint t[30] = '{
			64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
			64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
			64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
			64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
		return t[i];
	endfunction

	function automatic void half_trig(input ang_t a, output longint c, output longint s);
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		z = longint'(a) * (64'sd1 <<< (31 - AngleBits));
		x = 64'h26DD3B6A;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_of(i);
			end else begin
				x += dx; y -= dy; z += atan_of(i);
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint prod3(longint a, longint b, longint c);
		return ((a * b + (64'sd1 <<< 29)) >>> 30) * c;
	endfunction

	function automatic qc_t sat_round(longint v);
		longint r;
		r = (v + (64'sd1 <<< (59 - OutFracBits))) >>> (60 - OutFracBits);
		if (r > (64'sd1 <<< OutFracBits) - 1) r = (64'sd1 <<< OutFracBits) - 1;
		if (r < -(64'sd1 <<< OutFracBits)) r = -(64'sd1 <<< OutFracBits);
		return qc_t'(r);
	endfunction

	function automatic quat_t zyx_quat(ang_t p, ang_t r, ang_t a);
		longint cp, sp, cr, sr, cy, sy;
		quat_t q;
		half_trig(p, cp, sp);
		half_trig(r, cr, sr);
		half_trig(a, cy, sy);
		q.w = sat_round(prod3(cy, cr, cp) + prod3(sy, sr, sp));
		q.x = sat_round(prod3(cy, sr, cp) - prod3(sy, cr, sp));
		q.y = sat_round(prod3(cy, cr, sp) + prod3(sy, sr, cp));
		q.z = sat_round(prod3(sy, cr, cp) - prod3(cy, sr, sp));
		return q;
	endfunction

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// sender
	task automatic send(input ang_t p, input ang_t r, input ang_t a);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {a, r, p};
		quat_q.push_back(zyx_quat(p, r, a));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	vec_t dir_tab[] = '{
		'{16'sd0, 16'sd0, 16'sd0, 1, '{16'sd32767, 16'sd0, 16'sd0, 16'sd0}},
		'{-16'sd32768, 16'sd0, 16'sd0, 0, '{0, 0, 0, 0}},
		'{16'sd0, -16'sd32768, 16'sd0, 0, '{0, 0, 0, 0}},
		'{16'sd0, 16'sd0, -16'sd32768, 0, '{0, 0, 0, 0}},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 0, '{0, 0, 0, 0}},
		'{16'sd32767, 16'sd32767, 16'sd32767, 0, '{0, 0, 0, 0}},
		'{16'sd32767, 16'sd0, 16'sd0, 0, '{0, 0, 0, 0}},
		'{16'sd0, 16'sd32767, 16'sd0, 0, '{0, 0, 0, 0}},
		'{16'sd0, 16'sd0, 16'sd32767, 0, '{0, 0, 0, 0}},
		'{16'sd16384, 16'sd0, 16'sd0, 0, '{0, 0, 0, 0}},
		'{16'sd0, -16'sd16384, 16'sd0, 0, '{0, 0, 0, 0}},
		'{16'sd0, 16'sd0, 16'sd16384, 0, '{0, 0, 0, 0}},
		'{16'sd1, -16'sd1, 16'sd1, 0, '{0, 0, 0, 0}},
		'{-16'sd1, 16'sd1, -16'sd1, 0, '{0, 0, 0, 0}},
		'{16'sd8192, 16'sd8192, 16'sd8192, 0, '{0, 0, 0, 0}},
		'{-16'sd8192, 16'sd24576, -16'sd21845, 0, '{0, 0, 0, 0}},
		'{16'sh5555, -16'sh5556, 16'sh2AAA, 0, '{0, 0, 0, 0}},
		'{-16'sd32768, 16'sd32767, 16'sd0, 0, '{0, 0, 0, 0}}
	};

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		errors = 0;
		stim_done = 0;
		src_idle_pct = 29;
		snk_idle_pct = 59;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			send(dir_tab[i].pitch, dir_tab[i].roll, dir_tab[i].azim);
			// hand-typed result replaces the predicted one where given
			if (dir_tab[i].known) quat_q[$] = dir_tab[i].q;
		end
		for (int n = 0; n < NumRandom; n++) begin
			if (n == NumRandom / 3) begin
				src_idle_pct = 59; snk_idle_pct = 29;
			end else if (n == 2 * NumRandom / 3) begin
				src_idle_pct = 0; snk_idle_pct = 0;
			end
			case ($urandom_range(3))
				0: send(ang_t'($urandom), ang_t'($urandom), ang_t'($urandom));
				1: send(ang_t'($urandom_range(65535)), 16'sd0, ang_t'($urandom_range(511)));
				2: send(ang_t'({$urandom_range(3), 14'h0}), ang_t'($urandom), -16'sd32768);
				default: send(ang_t'($urandom_range(64) - 32), ang_t'($urandom),
					ang_t'($urandom_range(64) - 32));
			endcase
		end
		s_tvalid <= 0;
		stim_done = 1;
	end

	// receiver, with one long hold-off while the sender keeps going
	initial begin
		m_tready = 0;
		hold_off = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 0;
			end else if (quat_q.size() > 8 && hold_off == 0 && snk_idle_pct == 29
					&& src_idle_pct == 59) begin
				hold_off = 200;
				snk_idle_pct = 30;
				m_tready <= 0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		quat_t e;
		qc_t gw, gx, gy, gz;
		if (arst_n && m_tvalid && m_tready) begin
			{gz, gy, gx, gw} = m_tdata;
			if (quat_q.size() == 0) begin
				report("unexpected word", 0, 0);
			end else begin
				e = quat_q.pop_front();
				if (gw !== e.w) report("quat_w", gw, e.w);
				if (gx !== e.x) report("quat_x", gx, e.x);
				if (gy !== e.y) report("quat_y", gy, e.y);
				if (gz !== e.z) report("quat_z", gz, e.z);
			end
		end
	end

	// watchdog and end of run
	initial begin
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
			if (quiet >= StallLimit) begin
				$display("simulation failed");
				$finish;
			end
			if (stim_done && quat_q.size() == 0) begin
				repeat (PipeLatency + 10) @(posedge clk);
				if (errors == 0 && quat_q.size() == 0) begin
					$display("simulation ok");
				end else begin
					$display("simulation failed");
				end
				$finish;
			end
		end
	end
endmodule
